/* src/shlpi_pkg.sv */
// Shared types and constants for the string hash linear probe insert unit.
`default_nettype none

package shlpi_pkg;

   // Field widths fixed by the stream format
   localparam int CHAR_W     = 7;
   localparam int PAY_IN_W   = 32;
   localparam int CSR_W      = 11;
   localparam int SLOT_OUT_W = 10;
   localparam int CNT_W      = 11;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // Hash constants
   localparam int          HASH_W    = 32;
   localparam int          KEY_W     = 31;
   localparam logic [31:0] HASH_SEED = 32'd7;
   localparam logic [31:0] HASH_MULT = 32'd31;
   localparam logic [31:0] HASH_MASK = 32'h7FFF_FFFF;

   // Remainder unit: one quotient bit per cycle
   localparam int          STEP_W    = 5;
   localparam logic [4:0]  STEP_LAST = 5'(KEY_W - 1);

   // Reset value of the table size register
   localparam logic [CSR_W-1:0] SIZE_RESET = 11'd1024;

   // Result status codes
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_DONE
   } state_type;

   // Command to the remainder unit
   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] dividend;
   } mod_cmd_type;

endpackage

`default_nettype wire

/* src/shlpi_hash.sv */
// Running string hash: seed 7, times 31 plus character, per character.
`default_nettype none

module shlpi_hash
   import shlpi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              has_char,
   input  wire logic              last_char,
   input  wire logic [CHAR_W-1:0] char_code,
   output logic [HASH_W-1:0]      hash_fold
);

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic [HASH_W-1:0] hash_step;

   // Multiply by 31 as shift-and-subtract, then add the character
   assign hash_step = (hash_ff << 5) - hash_ff + HASH_W'(char_code);
   assign hash_fold = has_char ? hash_step : hash_ff;

   // Fold on each transfer, return to the seed after the last one
   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = last_char ? HASH_SEED : hash_fold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_SEED;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

`default_nettype wire

/* src/shlpi_mod_unit.sv */
// Iterative restoring remainder unit: one quotient bit per cycle.
`default_nettype none

module shlpi_mod_unit
   import shlpi_pkg::*;
#(
   parameter int DIV_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mod_cmd_type      cmd,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [KEY_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;

   // Shift in the next dividend bit and subtract when it fits
   assign trial = {rem_ff, dvd_ff[KEY_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = STEP_LAST;
         dvd_in  = cmd.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         rem_in  = (trial >= {1'b0, divisor}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* src/shlpi_table.sv */
// Slot table: occupied bits and payload words, one write and one read port.
`default_nettype none

module shlpi_table
   import shlpi_pkg::*;
#(
   parameter int TABLE_DEPTH   = 1024,
   parameter int PAYLOAD_WIDTH = 32,
   parameter int SLOT_W        = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [SLOT_W-1:0]        wr_addr,
   input  wire logic                     wr_occ,
   input  wire logic                     pay_wr_en,
   input  wire logic [PAYLOAD_WIDTH-1:0] wr_payload,
   input  wire logic [SLOT_W-1:0]        rd_addr,
   output logic                          rd_occ
);

   logic                     occ_mem [TABLE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] pay_mem [TABLE_DEPTH];
   logic                     rd_occ_ff;

   // Occupied map: written by the clearing pass and by inserts
   always_ff @(posedge clock) begin
      if (wr_en) begin
         occ_mem[wr_addr] <= wr_occ;
      end
      rd_occ_ff <= occ_mem[rd_addr];
   end

   // Payload store: written on insert only
   always_ff @(posedge clock) begin
      if (pay_wr_en) begin
         pay_mem[wr_addr] <= wr_payload;
      end
   end

   assign rd_occ = rd_occ_ff;

endmodule

`default_nettype wire

/* src/string_hash_linear_probe_insert_unit.sv */
// Top level: hash, modulo, linear probe and insert sequencer with result register.
// Sequence: a character transfer without tlast folds into the hash; a transfer with tlast
//   runs the remainder unit, then a read and a check per probed slot, then loads the
//   result register once it is free (no probing when the count shows a full table).
// Throughput: one character per cycle while idle; no transfer is taken while a name is processed.
// Reset: synchronous; afterwards a clearing pass sweeps every slot of the occupied
//   map, one slot per cycle, with req_tready low; csr writes are taken.
`default_nettype none

module string_hash_linear_probe_insert_unit
   import shlpi_pkg::*;
#(
   parameter int TABLE_DEPTH   = 1024,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data,  // table_size
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,    // [6:0] char_code, [38:7] token_payload
   input  wire logic                  req_tuser,    // has_char
   input  wire logic                  req_tlast,    // last_char
   // Response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,    // [9:0] slot_index
   output logic                       rsp_tuser     // status
);

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int CW     = (SLOT_W + 1 > 12) ? SLOT_W + 1 : 12;
   localparam logic [CW-1:0]     DEPTH_C   = CW'(TABLE_DEPTH);
   localparam logic [SLOT_W-1:0] CLR_LAST  = SLOT_W'(TABLE_DEPTH - 1);

   state_type state_ff, state_in;

   logic [CSR_W-1:0]         csr_ff, csr_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SLOT_W-1:0]        clr_ff, clr_in;
   logic [SLOT_W-1:0]        probe_ff, probe_in;
   logic [CW-1:0]            tries_ff, tries_in;
   logic [CW-1:0]            size_ff, size_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic                     res_stat_ff, res_stat_in;
   logic [SLOT_OUT_W-1:0]    res_slot_ff, res_slot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_stat_ff, rsp_stat_in;
   logic [SLOT_OUT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic                accept;
   logic [CHAR_W-1:0]   req_char;
   logic [PAY_IN_W-1:0] req_pay;
   logic [HASH_W-1:0]   hash_fold;
   logic [CW-1:0]       eff_size;
   logic [CW-1:0]       tries_next;
   logic [CW-1:0]       probe_next;
   logic                at_full;
   mod_cmd_type         mod_cmd;
   logic                mod_done;
   logic [CW-1:0]       mod_rem;
   logic                tbl_wr_en;
   logic [SLOT_W-1:0]   tbl_wr_addr;
   logic                tbl_wr_occ;
   logic                tbl_pay_wr_en;
   logic                tbl_rd_occ;
   logic                rsp_free;

   assign req_char = req_tdata[CHAR_W-1:0];
   assign req_pay  = req_tdata[CHAR_W + PAY_IN_W - 1:CHAR_W];
   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Clamp the size register to 1 .. TABLE_DEPTH
   always_comb begin
      eff_size = CW'(csr_ff);
      if (csr_ff == '0) begin
         eff_size = CW'(1);
      end else if (CW'(csr_ff) > DEPTH_C) begin
         eff_size = DEPTH_C;
      end
   end

   assign tries_next = tries_ff + 1'b1;
   assign probe_next = CW'(probe_ff) + 1'b1;
   assign at_full    = CW'(cnt_ff) >= size_ff;

   shlpi_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .has_char  (req_tuser),
      .last_char (req_tlast),
      .char_code (req_char),
      .hash_fold (hash_fold)
   );

   shlpi_mod_unit #(
      .DIV_W (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .cmd       (mod_cmd),
      .divisor   (size_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   shlpi_table #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
      .SLOT_W        (SLOT_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_wr_en),
      .wr_addr    (tbl_wr_addr),
      .wr_occ     (tbl_wr_occ),
      .pay_wr_en  (tbl_pay_wr_en),
      .wr_payload (pay_ff),
      .rd_addr    (probe_ff),
      .rd_occ     (tbl_rd_occ)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_tlast) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (mod_done) state_in = at_full ? ST_DONE : ST_PROBE_RD;
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            if (!tbl_rd_occ || tries_next == size_ff) state_in = ST_DONE;
            else                                      state_in = ST_PROBE_RD;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_tready       = 1'b0;
      mod_cmd.start    = 1'b0;
      mod_cmd.dividend = hash_fold[KEY_W-1:0] & HASH_MASK[KEY_W-1:0];
      tbl_wr_en        = 1'b0;
      tbl_wr_addr      = probe_ff;
      tbl_wr_occ       = 1'b1;
      tbl_pay_wr_en    = 1'b0;
      csr_in           = csr_wr_en ? csr_wr_data : csr_ff;
      cnt_in           = cnt_ff;
      clr_in           = clr_ff;
      probe_in         = probe_ff;
      tries_in         = tries_ff;
      size_in          = size_ff;
      pay_in           = pay_ff;
      res_stat_in      = res_stat_ff;
      res_slot_in      = res_slot_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_stat_in      = rsp_stat_ff;
      rsp_slot_in      = rsp_slot_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep the occupied map to empty
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_ff;
            tbl_wr_occ  = 1'b0;
            clr_in      = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && req_tlast) begin
               mod_cmd.start = 1'b1;
               size_in       = eff_size;
               pay_in        = PAYLOAD_WIDTH'(req_pay);
            end
         end
         ST_DIVIDE: begin
            // Home slot ready: start probing unless the count is at or above the size
            if (mod_done) begin
               probe_in    = mod_rem[SLOT_W-1:0];
               tries_in    = '0;
               res_stat_in = STAT_FULL;
               res_slot_in = '0;
            end
         end
         ST_PROBE_RD: begin
            // Read address is probe_ff; data returns next cycle
         end
         ST_PROBE_CHK: begin
            if (!tbl_rd_occ) begin
               tbl_wr_en     = 1'b1;
               tbl_pay_wr_en = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               res_stat_in   = STAT_OK;
               res_slot_in   = SLOT_OUT_W'(probe_ff);
            end else begin
               tries_in = tries_next;
               probe_in = (probe_next == size_ff) ? '0 : probe_next[SLOT_W-1:0];
            end
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_slot_in  = res_slot_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         csr_ff       <= SIZE_RESET;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      probe_ff    <= probe_in;
      tries_ff    <= tries_in;
      size_ff     <= size_in;
      pay_ff      <= pay_in;
      res_stat_ff <= res_stat_in;
      res_slot_ff <= res_slot_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_slot_ff);

endmodule

`default_nettype wire

/* src/shlpi_checker.sv */
// Port-level checks for the insert unit, bound to the top level.
`default_nettype none

module shlpi_checker
   import shlpi_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Report slot zero with a full status
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_FULL |-> rsp_tdata == '0)
      else $error("full status with nonzero slot");

   // Hold off requests and drop any result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");

   // Stay ready across a name that has not ended
   a_char_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> req_tready)
      else $error("ready dropped after a character transfer");

endmodule

bind string_hash_linear_probe_insert_unit shlpi_checker u_shlpi_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the string hash linear probe insert unit.
`timescale 1ns / 100ps

module testbench;
   import shlpi_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PHASE_ITEMS = 130;

   // One character transfer of a symbol name
   typedef struct {
      logic [CHAR_W-1:0]   char_code;
      logic                has_char;
      logic                last_char;
      logic [PAY_IN_W-1:0] token_payload;
   } name_item_type;

   // One insert outcome
   typedef struct {
      logic                  status;
      logic [SLOT_OUT_W-1:0] slot_index;
   } slot_result_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Stimulus and expectations
   name_item_type   name_items[$];
   name_item_type   in_flight;
   slot_result_type placed_slots[$];
   slot_result_type oldest_slot;

   // Shadow state of the table
   logic [CSR_W-1:0] size_reg;
   logic [31:0]      name_hash;
   bit               slot_taken[DEPTH];
   int               stored_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int cycles         = 0;
   int phase_count;

   string_hash_linear_probe_insert_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [6:0] char_code, [38:7] token_payload
      .req_tuser   (req_tuser),    // has_char
      .req_tlast   (req_tlast),    // last_char
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [9:0] slot_index
      .rsp_tuser   (rsp_tuser)     // status
   );

   // Clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL string_hash_linear_probe_insert_unit");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input int want, input int got);
      $display("mismatch: %s expected %0d got %0d (cycle %0d)", what, want, got, cycles);
      mismatches++;
   endtask

   // Fold one accepted character into the hash; on a name end, place it in the table
   task automatic hash_and_place(input name_item_type it);
      logic [31:0]     eff;
      logic [31:0]     home;
      int              p;
      slot_result_type res;
      if (it.has_char)
         name_hash = name_hash * HASH_MULT + {25'd0, it.char_code};
      if (!it.last_char)
         return;
      eff = {21'd0, size_reg};
      if (eff == 0)
         eff = 1;
      if (eff > DEPTH)
         eff = DEPTH;
      home = (name_hash & HASH_MASK) % eff;
      name_hash = HASH_SEED;
      res.status = STAT_FULL;
      res.slot_index = '0;
      if (stored_count < int'(eff)) begin
         for (int i = 0; i < int'(eff); i++) begin
            p = int'(home) + i;
            if (p >= int'(eff))
               p -= int'(eff);
            if (!slot_taken[p]) begin
               slot_taken[p] = 1'b1;
               stored_count++;
               res.status = STAT_OK;
               res.slot_index = SLOT_OUT_W'(p);
               break;
            end
         end
      end
      placed_slots.push_back(res);
   endtask

   // Request driver: hold each item until its transfer, then fetch the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            hash_and_place(in_flight);
         if (!req_tvalid || req_tready) begin
            if (name_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = name_items.pop_front();
               req_tdata  <= {1'b0, in_flight.token_payload, in_flight.char_code};
               req_tuser  <= in_flight.has_char;
               req_tlast  <= in_flight.last_char;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stall at random and check each transfer against the oldest insert
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (placed_slots.size() == 0) begin
               flag_mismatch("result with no name pending, slot", -1, int'(rsp_tdata[9:0]));
            end else begin
               oldest_slot = placed_slots.pop_front();
               if (rsp_tuser !== oldest_slot.status)
                  flag_mismatch("status", int'(oldest_slot.status), int'(rsp_tuser));
               if (rsp_tdata[SLOT_OUT_W-1:0] !== oldest_slot.slot_index)
                  flag_mismatch("slot_index", int'(oldest_slot.slot_index),
                                int'(rsp_tdata[SLOT_OUT_W-1:0]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_item(input logic [CHAR_W-1:0] ch, input logic has, input logic last,
                             input logic [PAY_IN_W-1:0] payload);
      name_item_type it;
      it.char_code     = ch;
      it.has_char      = has;
      it.last_char     = last;
      it.token_payload = payload;
      name_items.push_back(it);
   endtask

   // Random name of len characters; a blank tail ends it on an item with no character
   task automatic queue_name(input int len, input bit blank_tail);
      for (int k = 0; k < len; k++)
         queue_item(CHAR_W'($urandom_range(127)), 1'b1, (k == len - 1) && !blank_tail,
                    $urandom);
      if (blank_tail)
         queue_item(CHAR_W'($urandom_range(127)), 1'b0, 1'b1, $urandom);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;  recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 46; recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;  recv_stall_pct = 46;
         end
         default: begin
            send_idle_pct = 21; recv_stall_pct = 21;
         end
      endcase
   endtask

   // Wait until every item has transferred and every result has come back;
   // sample between edges so the driver's updates at the edge are settled
   task automatic drain;
      @(negedge clock);
      while (name_items.size() > 0 || req_tvalid || placed_slots.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      size_reg    = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus sequence
   initial begin
      int            sizes[12];
      int            len;
      idle_mode_type mode;
      sizes = '{24, 1024, 512, 2047, 1024, 7, 1000, 0, 1025, 1024, 300, 1};
      size_reg  = SIZE_RESET;
      name_hash = HASH_SEED;
      stored_count = 0;
      foreach (slot_taken[i])
         slot_taken[i] = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset table size, empty names, idle item, character extremes
      queue_item(7'd0, 1'b0, 1'b1, 32'h0000_0000);
      queue_item(7'd127, 1'b0, 1'b0, 32'hFFFF_FFFF);
      queue_item(7'd0, 1'b0, 1'b1, 32'hFFFF_FFFF);
      queue_item(7'd0, 1'b1, 1'b0, 32'h0000_0000);
      queue_item(7'd127, 1'b1, 1'b1, 32'hFFFF_FFFF);
      queue_item(7'd65, 1'b1, 1'b0, 32'h5555_5555);
      queue_item(7'd0, 1'b0, 1'b1, 32'hAAAA_AAAA);
      queue_item(7'd127, 1'b1, 1'b1, 32'h8000_0001);
      drain();

      // Size zero acts as one: the count already exceeds it, so both names find the table full
      set_table_size(11'd0);
      queue_item(7'd66, 1'b1, 1'b1, 32'h1234_5678);
      queue_item(7'd67, 1'b1, 1'b1, 32'h8765_4321);
      drain();

      // Size above the table depth acts as the full depth
      set_table_size(11'd2047);
      queue_name(3, 1'b0);
      queue_name(2, 1'b1);
      drain();

      // Size one with entries already counted: full
      set_table_size(11'd1);
      queue_item(7'd120, 1'b1, 1'b1, 32'hDEAD_BEEF);
      drain();

      set_table_size(11'd1025);
      queue_name(4, 1'b0);
      drain();

      // Random phases: names with random content, a few idle items as noise
      for (int ph = 0; ph < 12; ph++) begin
         set_table_size(CSR_W'(sizes[ph]));
         mode = idle_mode_type'(ph % 4);
         set_idling(mode);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            if ($urandom_range(19) == 0) begin
               queue_item(CHAR_W'($urandom_range(127)), 1'b0, 1'b0, $urandom);
            end else if ($urandom_range(29) == 0) begin
               queue_name(0, 1'b1);
               phase_count += 1;
            end else begin
               len = $urandom_range(1, 10);
               if ($urandom_range(9) == 0) begin
                  queue_name(len, 1'b1);
                  phase_count += len + 1;
               end else begin
                  queue_name(len, 1'b0);
                  phase_count += len;
               end
            end
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS string_hash_linear_probe_insert_unit");
      end else begin
         $display("FAIL string_hash_linear_probe_insert_unit");
      end
      $finish;
   end

endmodule
